>>> design/cfp_pkg.sv
// cfp_pkg: shared types, codes and constants of the command frame parser.
// Used by every module in this folder but cfp_ram; depends on nothing.
package cfp_pkg;

	localparam int PARAM_DEPTH_DEF = 63;

	localparam int BYTE_W    = 8;
	localparam int LIMIT_W   = 7;
	localparam int STATUS_W  = 2;
	localparam int PCOUNT_W  = 6;
	localparam int CFG_IDX_W = 3;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_INVALID  = 2'd1;
	localparam status_t STATUS_MISMATCH = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD      = 3'd0,
		REG_TAIL      = 3'd1,
		REG_ID_LOW    = 3'd2,
		REG_ID_HIGH   = 3'd3,
		REG_BROADCAST = 3'd4,
		REG_LOCAL     = 3'd5,
		REG_LIMIT     = 3'd6
	} cfg_reg_t;

	localparam byte_t               HEAD_RST      = 8'd35;
	localparam byte_t               TAIL_RST      = 8'd10;
	localparam byte_t               ID_LOW_RST    = 8'd1;
	localparam byte_t               ID_HIGH_RST   = 8'd31;
	localparam byte_t               BROADCAST_RST = 8'd0;
	localparam byte_t               LOCAL_RST     = 8'd1;
	localparam logic [LIMIT_W-1:0] LIMIT_RST     = 7'd64;

	localparam byte_t CHAR_A = 8'h41;
	localparam byte_t CHAR_Z = 8'h5A;

	// controller -> datapath commands
	typedef struct packed {
		logic accept; // input word taken this cycle
		logic judge;  // latch frame status
		logic rd;     // read parameter store, advance item index
		logic load;   // load output register
		logic clear;  // drop frame state after last item
	} dp_cmd_t;

endpackage

>>> design/command_frame_parser.sv
// command_frame_parser: top level of the byte-serial command frame parser.
// Depends on cfp_pkg, cfp_ctrl, cfp_datapath (which holds cfp_ram).
module command_frame_parser #(
	parameter int PARAM_DEPTH = cfp_pkg::PARAM_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cfp_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cfp_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          end_of_buffer,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cfp_pkg::STATUS_W-1:0]  status,
	output logic [cfp_pkg::BYTE_W-1:0]    node_id,
	output logic [cfp_pkg::BYTE_W-1:0]    command_letter,
	output logic [cfp_pkg::BYTE_W-1:0]    sub_letter,
	output logic [cfp_pkg::PCOUNT_W-1:0]  param_count,
	output logic                          has_params,
	output logic [cfp_pkg::BYTE_W-1:0]    param_byte,
	output logic                          last
);
	// Parses a received buffer one word per cycle while in_ready is high;
	// end_of_buffer flags the last byte. The first head byte opens a frame,
	// the next three bytes are taken as id, command letter and sub letter,
	// then bytes up to the first tail byte are parameters, kept in a
	// PARAM_DEPTH-entry RAM (count saturates at PARAM_DEPTH+1). Non-final
	// bytes produce nothing. After the final byte the block stops taking
	// input, judges the frame, then for each result word reads the RAM and
	// loads the output register. A run is n = parameter count words when
	// status is ok and parameters exist, else one word with has_params 0;
	// last marks its final word. Input reopens as soon as the final word is
	// loaded, so the next buffer streams in while that word waits on
	// out_ready.
	// Status checks, in order: no frame -> invalid; id out of range and not
	// broadcast -> invalid; id not local and not broadcast -> mismatch;
	// a letter outside A..Z -> invalid; count not below param_limit (or
	// above PARAM_DEPTH) -> invalid. Id, letters and count read as zero
	// unless status is ok. Config writes (index 0..6: head, tail, id_low,
	// id_high, broadcast, local, param_limit) are always accepted and must
	// be issued only while the block is idle; other indexes are ignored.
	import cfp_pkg::*;

	dp_cmd_t cmd;
	logic    last_item;

	assign cfg_ready = 1'b1;

	cfp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.end_of_buffer(end_of_buffer),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.last_item    (last_item),
		.cmd          (cmd)
	);

	cfp_datapath #(
		.PARAM_DEPTH(PARAM_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.last_item     (last_item),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_byte     (data_byte),
		.status        (status),
		.node_id       (node_id),
		.command_letter(command_letter),
		.sub_letter    (sub_letter),
		.param_count   (param_count),
		.has_params    (has_params),
		.param_byte    (param_byte),
		.last          (last)
	);

endmodule

>>> design/cfp_ram.sv
// cfp_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module cfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/cfp_ctrl.sv
// cfp_ctrl: sequencer of the command frame parser (input gating, result run).
// Depends on cfp_pkg; drives cfp_datapath through dp_cmd_t.
module cfp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             end_of_buffer,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             last_item,
	output cfp_pkg::dp_cmd_t cmd
);
	import cfp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_JUDGE = 4'b0010,
		ST_RD    = 4'b0100,
		ST_LOAD  = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.judge  = (state_q == ST_JUDGE);
		cmd.rd     = (state_q == ST_RD);
		cmd.load   = (state_q == ST_LOAD) && out_free;
		cmd.clear  = cmd.load && last_item;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && end_of_buffer) begin
					state_d = ST_JUDGE;
				end
			end
			ST_JUDGE: state_d = ST_RD;
			ST_RD:    state_d = ST_LOAD;
			ST_LOAD: begin
				if (cmd.load) begin
					state_d = last_item ? ST_IDLE : ST_RD;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// final word of a buffer always starts a judge
	a_fin_judge: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && end_of_buffer |=> state_q == ST_JUDGE)
		else $error("final word did not start judge");

	// a load never overwrites a pending result
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) && !out_free |=> state_q == ST_LOAD)
		else $error("left load while output busy");

	// a loaded item is offered next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("loaded item not presented");

endmodule

>>> design/cfp_datapath.sv
// cfp_datapath: config registers, frame parse state, parameter store, judge
// logic and output register. Depends on cfp_pkg and cfp_ram.
module cfp_datapath #(
	parameter int PARAM_DEPTH = cfp_pkg::PARAM_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cfp_pkg::dp_cmd_t                cmd,
	output logic                            last_item,
	input  logic                            cfg_we,
	input  logic [cfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfp_pkg::BYTE_W-1:0]      cfg_data,
	input  logic [cfp_pkg::BYTE_W-1:0]      data_byte,
	output logic [cfp_pkg::STATUS_W-1:0]    status,
	output logic [cfp_pkg::BYTE_W-1:0]      node_id,
	output logic [cfp_pkg::BYTE_W-1:0]      command_letter,
	output logic [cfp_pkg::BYTE_W-1:0]      sub_letter,
	output logic [cfp_pkg::PCOUNT_W-1:0]    param_count,
	output logic                            has_params,
	output logic [cfp_pkg::BYTE_W-1:0]      param_byte,
	output logic                            last
);
	import cfp_pkg::*;

	localparam int CW     = $clog2(PARAM_DEPTH + 2);
	localparam int AW     = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
	localparam int CMP_W  = (CW > LIMIT_W) ? CW : LIMIT_W;

	typedef enum logic [3:0] {
		PH_SEARCH = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_PARAMS = 4'b0100,
		PH_FOUND  = 4'b1000
	} phase_t;

	// configuration
	byte_t               head_q, tail_q, id_low_q, id_high_q, bcast_q, local_q;
	logic [LIMIT_W-1:0]  limit_q;

	// frame state
	phase_t      phase_q;
	logic [1:0]  pos_q;
	byte_t       id_q, cmd_q, sub_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] k_q;
	status_t     st_q;

	// store
	logic        ram_we;
	byte_t       ram_rdata;

	// judge
	status_t st_d;
	logic    bc, in_rng, letters_ok, count_bad, ok, hp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= HEAD_RST;
			tail_q    <= TAIL_RST;
			id_low_q  <= ID_LOW_RST;
			id_high_q <= ID_HIGH_RST;
			bcast_q   <= BROADCAST_RST;
			local_q   <= LOCAL_RST;
			limit_q   <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEAD:      head_q    <= cfg_data;
				REG_TAIL:      tail_q    <= cfg_data;
				REG_ID_LOW:    id_low_q  <= cfg_data;
				REG_ID_HIGH:   id_high_q <= cfg_data;
				REG_BROADCAST: bcast_q   <= cfg_data;
				REG_LOCAL:     local_q   <= cfg_data;
				REG_LIMIT:     limit_q   <= cfg_data[LIMIT_W-1:0];
				default:       ;
			endcase
		end
	end

	assign ram_we = cmd.accept && (phase_q == PH_PARAMS) && (data_byte != tail_q)
		&& (cnt_q < CW'(PARAM_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			pos_q   <= 2'd0;
			cnt_q   <= '0;
			k_q     <= '0;
			st_q    <= STATUS_INVALID;
		end else begin
			if (cmd.clear) begin
				phase_q <= PH_SEARCH;
				pos_q   <= 2'd0;
				cnt_q   <= '0;
			end else if (cmd.accept) begin
				case (phase_q)
					PH_SEARCH: begin
						if (data_byte == head_q) begin
							phase_q <= PH_HEADER;
							pos_q   <= 2'd0;
						end
					end
					PH_HEADER: begin
						if (pos_q == 2'd2) begin
							phase_q <= PH_PARAMS;
						end else begin
							pos_q <= pos_q + 2'd1;
						end
					end
					PH_PARAMS: begin
						if (data_byte == tail_q) begin
							phase_q <= PH_FOUND;
						end else if (cnt_q <= CW'(PARAM_DEPTH)) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.judge) begin
				st_q <= st_d;
				k_q  <= '0;
			end else if (cmd.rd) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// header bytes, payload only
	always_ff @(posedge clk) begin
		if (cmd.accept && phase_q == PH_HEADER) begin
			case (pos_q)
				2'd0:    id_q  <= data_byte;
				2'd1:    cmd_q <= data_byte;
				default: sub_q <= data_byte;
			endcase
		end
	end

	cfp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PARAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(data_byte),
		.re   (cmd.rd),
		.raddr(k_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		bc         = (id_q == bcast_q);
		in_rng     = (id_q >= id_low_q) && (id_q <= id_high_q);
		letters_ok = (cmd_q >= CHAR_A) && (cmd_q <= CHAR_Z)
			&& (sub_q >= CHAR_A) && (sub_q <= CHAR_Z);
		count_bad  = (cnt_q > CW'(PARAM_DEPTH)) || (CMP_W'(cnt_q) >= CMP_W'(limit_q));
		if (phase_q != PH_FOUND) begin
			st_d = STATUS_INVALID;
		end else if (!bc && !in_rng) begin
			st_d = STATUS_INVALID;
		end else if (!bc && (id_q != local_q)) begin
			st_d = STATUS_MISMATCH;
		end else if (!letters_ok || count_bad) begin
			st_d = STATUS_INVALID;
		end else begin
			st_d = STATUS_OK;
		end
	end

	assign ok        = (st_q == STATUS_OK);
	assign hp        = ok && (cnt_q != '0);
	// k_q already advanced past the item being loaded
	assign last_item = hp ? (k_q == cnt_q) : 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status         <= st_q;
			node_id        <= ok ? id_q : '0;
			command_letter <= ok ? cmd_q : '0;
			sub_letter     <= ok ? sub_q : '0;
			param_count    <= ok ? PCOUNT_W'(cnt_q) : '0;
			has_params     <= hp;
			param_byte     <= hp ? ram_rdata : '0;
			last           <= last_item;
		end
	end

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(PARAM_DEPTH + 1))
		else $error("parameter count past saturation");

	a_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.judge && (phase_q != PH_FOUND) |=> st_q == STATUS_INVALID)
		else $error("unfound frame not judged invalid");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (phase_q == PH_SEARCH) && (cnt_q == '0))
		else $error("frame state not dropped after run");

endmodule

>>> test/tb_command_frame_parser.sv
// tb_command_frame_parser: self-checking testbench for the command frame parser.
// Depends on cfp_pkg and the command_frame_parser RTL; reads no files.
module tb_command_frame_parser;
	import cfp_pkg::*;

	localparam int DEPTH     = PARAM_DEPTH_DEF;
	localparam int DRAIN_CYC = 32;      // quiet cycles before a register write and at the end
	localparam int LIMIT_CYC = 300000;  // hard stop, far above the slowest legal run

	// one input word as queued for the sender; fixed rows carry a hand-typed status
	typedef struct packed {
		byte_t   data;
		logic    eob;
		logic    fixed;
		status_t fixed_status;
	} rx_byte_t;

	// one output word as the block should present it
	typedef struct packed {
		status_t               status;
		byte_t                 node_id;
		byte_t                 command_letter;
		byte_t                 sub_letter;
		logic [PCOUNT_W-1:0]   param_count;
		logic                  has_params;
		byte_t                 param_byte;
		logic                  last;
	} frame_word_t;

	typedef enum logic [1:0] {SEEK_HEAD, IN_HEADER, IN_PARAMS, FRAME_FOUND} scan_phase_t;

	// ---------------- clock, reset, DUT ports ----------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HEAD;
	byte_t                cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	byte_t                data_byte = '0;
	logic                 end_of_buffer = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	status_t              status;
	byte_t                node_id;
	byte_t                command_letter;
	byte_t                sub_letter;
	logic [PCOUNT_W-1:0]  param_count;
	logic                 has_params;
	byte_t                param_byte;
	logic                 last;

	command_frame_parser #(.PARAM_DEPTH(DEPTH)) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_buffer  (end_of_buffer),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.node_id        (node_id),
		.command_letter (command_letter),
		.sub_letter     (sub_letter),
		.param_count    (param_count),
		.has_params     (has_params),
		.param_byte     (param_byte),
		.last           (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// single reset pulse
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------- shadow registers and frame state of the predictor ----------------
	byte_t               c_head   = HEAD_RST;
	byte_t               c_tail   = TAIL_RST;
	byte_t               c_id_low = ID_LOW_RST;
	byte_t               c_id_high = ID_HIGH_RST;
	byte_t               c_bcast  = BROADCAST_RST;
	byte_t               c_local  = LOCAL_RST;
	logic [LIMIT_W-1:0]  c_limit  = LIMIT_RST;

	scan_phase_t         fr_phase = SEEK_HEAD;
	logic [2:0]          fr_pos   = '0;
	byte_t               fr_id    = '0;
	byte_t               fr_cmd   = '0;
	byte_t               fr_sub   = '0;
	byte_t               fr_store [DEPTH];
	logic [LIMIT_W-1:0]  fr_count = '0;

	rx_byte_t    send_q[$];        // words waiting for the sender
	frame_word_t pending_words[$]; // output words predicted but not yet seen
	rx_byte_t    cur_byte;         // word currently on the input port

	int bytes_queued = 0;
	int bytes_taken  = 0;
	int rand_bytes   = 0;
	int n_errors     = 0;
	int cycles       = 0;

	// Directed buffers, default registers. Typed status only where it is obvious:
	// a buffer with no head, a frame cut off before its tail, an address mismatch.
	rx_byte_t dir_tbl [25] = '{
		// no head byte at all, single all-ones word
		'{8'hFF,         1'b1, 1'b1, STATUS_INVALID},
		// header complete, parameter taken, buffer ends before any tail
		'{HEAD_RST,      1'b0, 1'b0, STATUS_OK},
		'{8'd1,          1'b0, 1'b0, STATUS_OK},
		'{CHAR_A,        1'b0, 1'b0, STATUS_OK},
		'{8'h42,         1'b0, 1'b0, STATUS_OK},
		'{8'h00,         1'b1, 1'b1, STATUS_INVALID},
		// good frame to the local id, params 00/FF, then junk and a second head, ignored
		'{HEAD_RST,      1'b0, 1'b0, STATUS_OK},
		'{8'd1,          1'b0, 1'b0, STATUS_OK},
		'{CHAR_A,        1'b0, 1'b0, STATUS_OK},
		'{CHAR_Z,        1'b0, 1'b0, STATUS_OK},
		'{8'h00,         1'b0, 1'b0, STATUS_OK},
		'{8'hFF,         1'b0, 1'b0, STATUS_OK},
		'{TAIL_RST,      1'b0, 1'b0, STATUS_OK},
		'{8'h55,         1'b0, 1'b0, STATUS_OK},
		'{HEAD_RST,      1'b1, 1'b0, STATUS_OK},
		// broadcast with no params, buffer ends on the tail
		'{HEAD_RST,      1'b0, 1'b0, STATUS_OK},
		'{BROADCAST_RST, 1'b0, 1'b0, STATUS_OK},
		'{8'h4D,         1'b0, 1'b0, STATUS_OK},
		'{8'h4E,         1'b0, 1'b0, STATUS_OK},
		'{TAIL_RST,      1'b1, 1'b0, STATUS_OK},
		// id in range but not ours
		'{HEAD_RST,      1'b0, 1'b0, STATUS_OK},
		'{8'd5,          1'b0, 1'b0, STATUS_OK},
		'{CHAR_A,        1'b0, 1'b0, STATUS_OK},
		'{8'h51,         1'b0, 1'b0, STATUS_OK},
		'{TAIL_RST,      1'b1, 1'b1, STATUS_MISMATCH}
	};

	// ---------------- predictor ----------------
	function automatic logic is_letter(byte_t c);
		return c >= CHAR_A && c <= CHAR_Z;
	endfunction

	// status of the frame held at the final byte, checks in priority order
	function automatic status_t judge_frame();
		logic bc;
		bc = (fr_id == c_bcast);
		if (fr_phase != FRAME_FOUND)
			return STATUS_INVALID;
		if (!bc && !(fr_id >= c_id_low && fr_id <= c_id_high))
			return STATUS_INVALID;
		if (!bc && fr_id != c_local)
			return STATUS_MISMATCH;
		if (!is_letter(fr_cmd) || !is_letter(fr_sub))
			return STATUS_INVALID;
		if (fr_count > DEPTH || fr_count >= c_limit)
			return STATUS_INVALID;
		return STATUS_OK;
	endfunction

	// advance the frame scan by one byte; on the final byte queue the output run
	task automatic parse_byte(input rx_byte_t rb);
		status_t     st;
		logic        ok;
		logic        hp;
		int          n;
		frame_word_t w;
		case (fr_phase)
			SEEK_HEAD: begin
				if (rb.data == c_head) begin
					fr_phase = IN_HEADER;
					fr_pos = '0;
				end
			end
			IN_HEADER: begin
				// id, command, sub: taken as they come, a tail here is just data
				if (fr_pos == 0)
					fr_id = rb.data;
				else if (fr_pos == 1)
					fr_cmd = rb.data;
				else
					fr_sub = rb.data;
				fr_pos = fr_pos + 3'd1;
				if (fr_pos >= 3)
					fr_phase = IN_PARAMS;
			end
			IN_PARAMS: begin
				if (rb.data == c_tail) begin
					fr_phase = FRAME_FOUND;
				end else begin
					// store drops bytes past its depth, count sticks at depth+1
					if (fr_count < DEPTH)
						fr_store[fr_count] = rb.data;
					if (fr_count <= DEPTH)
						fr_count = fr_count + 7'd1;
				end
			end
			default: ;
		endcase
		if (rb.eob) begin
			st = judge_frame();
			ok = (st == STATUS_OK);
			hp = ok && fr_count > 0;
			n = hp ? int'(fr_count) : 1;
			for (int k = 0; k < n; k++) begin
				w = '0;
				w.status = st;
				if (ok) begin
					w.node_id = fr_id;
					w.command_letter = fr_cmd;
					w.sub_letter = fr_sub;
					w.param_count = fr_count[PCOUNT_W-1:0];
				end
				w.has_params = hp;
				w.param_byte = hp ? fr_store[k] : '0;
				w.last = (k == n - 1);
				if (rb.fixed) begin
					// hand-typed row: error run is a single all-zero word
					w = '0;
					w.status = rb.fixed_status;
					w.last = 1'b1;
				end
				pending_words.push_back(w);
			end
			fr_phase = SEEK_HEAD;
			fr_pos = '0;
			fr_id = '0;
			fr_cmd = '0;
			fr_sub = '0;
			fr_count = '0;
		end
	endtask

	// ---------------- input side: bursts with random gaps ----------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_byte(cur_byte);
				bytes_taken++;
			end
			// valid may only change once the current word is gone
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (send_q.size() > 0) begin
					cur_byte = send_q.pop_front();
					data_byte <= cur_byte.data;
					end_of_buffer <= cur_byte.eob;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						// a third of bursts are followed by a gap, the rest run back to back
						gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: stall pattern redrawn whenever stall_tick wraps
	logic [5:0] stall_tick = '0;
	int         stall_mode = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			stall_tick <= stall_tick + 6'd1;
			if (stall_tick == 0)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_ready <= 1'b1;                           // never stall
				1: out_ready <= 1'($urandom_range(0, 1));       // coin toss
				default: out_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
			endcase
		end
	end

	// ---------------- result checker ----------------
	function automatic void cmp_field(string name, logic [7:0] exp, logic [7:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin
		frame_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("output word with none expected: status %0d", status);
				n_errors++;
			end else begin
				w = pending_words.pop_front();
				cmp_field("status", 8'(w.status), 8'(status));
				cmp_field("node_id", w.node_id, node_id);
				cmp_field("command_letter", w.command_letter, command_letter);
				cmp_field("sub_letter", w.sub_letter, sub_letter);
				cmp_field("param_count", 8'(w.param_count), 8'(param_count));
				cmp_field("has_params", 8'(w.has_params), 8'(has_params));
				cmp_field("param_byte", w.param_byte, param_byte);
				cmp_field("last", 8'(w.last), 8'(last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYC) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------
	// all words taken, all results seen, then DRAIN_CYC quiet cycles
	task automatic wait_idle();
		do
			@(negedge clk);
		while (bytes_taken != bytes_queued || pending_words.size() != 0);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input byte_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_HEAD:      c_head = val;
			REG_TAIL:      c_tail = val;
			REG_ID_LOW:    c_id_low = val;
			REG_ID_HIGH:   c_id_high = val;
			REG_BROADCAST: c_bcast = val;
			REG_LOCAL:     c_local = val;
			REG_LIMIT:     c_limit = val[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// letters sit mostly inside A..Z, with the neighbors of both ends now and then
	function automatic byte_t pick_letter(input logic good);
		if (good)
			return byte_t'($urandom_range(CHAR_A, CHAR_Z));
		case ($urandom_range(0, 9))
			0: return byte_t'(CHAR_A - 1);
			1: return byte_t'(CHAR_Z + 1);
			2: return byte_t'($urandom_range(0, 255));
			3: return CHAR_A;
			4: return CHAR_Z;
			default: return byte_t'($urandom_range(CHAR_A, CHAR_Z));
		endcase
	endfunction

	// Queue one buffer. Mostly well-formed frames with random content; the rest is
	// pure noise, frames without a tail, or frames cut short. A forced count gives
	// a clean broadcast frame with exactly that many params.
	task automatic queue_buffer(input int force_count);
		rx_byte_t frame_q[$];
		rx_byte_t item;
		int       kind;
		int       n_par;
		int       keep;
		byte_t    b;
		item = '0;
		kind = (force_count >= 0) ? 9 : $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 6)) begin
				item.data = byte_t'($urandom_range(0, 255));
				frame_q.push_back(item);
			end
		end else begin
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) begin
				do
					b = byte_t'($urandom_range(0, 255));
				while (b == c_head);
				item.data = b;
				frame_q.push_back(item);
			end
			item.data = c_head;
			frame_q.push_back(item);
			case ($urandom_range(0, 8))
				0, 1, 2: item.data = c_local;
				3: item.data = c_bcast;
				4: item.data = c_id_low;
				5: item.data = c_id_high;
				6: item.data = byte_t'(c_id_low - 1);
				7: item.data = byte_t'(c_id_high + 1);
				default: item.data = byte_t'($urandom_range(0, 255));
			endcase
			if (force_count >= 0)
				item.data = c_bcast;
			frame_q.push_back(item);
			item.data = pick_letter(force_count >= 0);
			frame_q.push_back(item);
			item.data = pick_letter(force_count >= 0);
			frame_q.push_back(item);
			if (force_count >= 0)
				n_par = force_count;
			else if ($urandom_range(0, 9) == 0)
				n_par = c_limit - 1 + $urandom_range(0, 1); // right at the limit
			else
				n_par = $urandom_range(0, 6);
			repeat (n_par) begin
				do
					b = byte_t'($urandom_range(0, 255));
				while (b == c_tail);
				item.data = b;
				frame_q.push_back(item);
			end
			if (kind != 1) begin
				item.data = c_tail;
				frame_q.push_back(item);
			end
			if (force_count < 0) begin
				repeat ($urandom_range(0, 2)) begin
					item.data = byte_t'($urandom_range(0, 255));
					frame_q.push_back(item);
				end
			end
			if (kind == 2) begin
				keep = $urandom_range(1, frame_q.size());
				while (frame_q.size() > keep)
					void'(frame_q.pop_back());
			end
		end
		frame_q[frame_q.size() - 1].eob = 1'b1;
		foreach (frame_q[i])
			send_q.push_back(frame_q[i]);
		bytes_queued += frame_q.size();
		rand_bytes += frame_q.size();
	endtask

	// ---------------- main sequence ----------------
	initial begin
		byte_t regv [7];
		int    p;
		int    start_bytes;
		wait (arst_n);
		@(negedge clk);

		// directed part under reset values
		foreach (dir_tbl[i])
			send_q.push_back(dir_tbl[i]);
		bytes_queued += $size(dir_tbl);
		wait_idle();

		// Random part in three phases. The first two are the register extremes,
		// the second also with an empty id range and a completely filled store.
		p = 0;
		while (p < 3) begin
			case (p)
				0: begin
					regv[REG_HEAD] = 8'h00;
					regv[REG_TAIL] = 8'hFF;
					regv[REG_ID_LOW] = 8'h00;
					regv[REG_ID_HIGH] = 8'hFF;
					regv[REG_BROADCAST] = 8'hFF;
					regv[REG_LOCAL] = 8'h00;
					regv[REG_LIMIT] = 8'd1;
				end
				1: begin
					regv[REG_HEAD] = 8'hFF;
					regv[REG_TAIL] = 8'h00;
					regv[REG_ID_LOW] = 8'd200;
					regv[REG_ID_HIGH] = 8'd100;
					regv[REG_BROADCAST] = 8'd7;
					regv[REG_LOCAL] = 8'd150;
					regv[REG_LIMIT] = 8'd64;
				end
				default: begin
					regv[REG_HEAD] = byte_t'($urandom_range(0, 255));
					regv[REG_TAIL] = byte_t'($urandom_range(0, 255));
					regv[REG_ID_LOW] = byte_t'($urandom_range(0, 127));
					regv[REG_ID_HIGH] = byte_t'(regv[REG_ID_LOW] + $urandom_range(0, 128));
					regv[REG_BROADCAST] = byte_t'($urandom_range(0, 255));
					regv[REG_LOCAL] = ($urandom_range(0, 3) == 0)
						? byte_t'($urandom_range(0, 255))
						: byte_t'($urandom_range(regv[REG_ID_LOW], regv[REG_ID_HIGH]));
					regv[REG_LIMIT] = byte_t'($urandom_range(1, 64));
				end
			endcase
			write_reg(REG_HEAD, regv[REG_HEAD]);
			write_reg(REG_TAIL, regv[REG_TAIL]);
			write_reg(REG_ID_LOW, regv[REG_ID_LOW]);
			write_reg(REG_ID_HIGH, regv[REG_ID_HIGH]);
			write_reg(REG_BROADCAST, regv[REG_BROADCAST]);
			write_reg(REG_LOCAL, regv[REG_LOCAL]);
			write_reg(REG_LIMIT, regv[REG_LIMIT]);
			@(negedge clk);
			if (p == 1)
				queue_buffer(DEPTH);     // store filled to the last entry
			start_bytes = rand_bytes;
			while (rand_bytes - start_bytes < 12)
				queue_buffer(-1);
			wait_idle();
			p++;
		end

		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
